// ----- design/vcpf_pkg.sv -----
// shared types, constants and register codes of the voxel capped point filter
package vcpf_pkg;

	localparam int GRID_X_DEF = 16;
	localparam int GRID_Y_DEF = 16;
	localparam int GRID_Z_DEF = 16;

	localparam int IDX_W    = 12;
	localparam int DEPTH    = 1 << IDX_W;
	localparam int CRD_W    = 8;
	localparam int CNT_W    = 8;
	localparam int EPOCH_W  = 8;
	localparam int Q_DEPTH  = 4;
	localparam int QA_W     = $clog2(Q_DEPTH);
	localparam int ADDR_W   = 5;

	typedef enum logic [2:0] {
		ST_KEPT    = 3'd0,
		ST_FULL    = 3'd1,
		ST_INVALID = 3'd2,
		ST_OUTSIDE = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_INV_X  = 3'd0,
		REG_INV_Y  = 3'd1,
		REG_INV_Z  = 3'd2,
		REG_ORG_X  = 3'd3,
		REG_ORG_Y  = 3'd4,
		REG_ORG_Z  = 3'd5,
		REG_CAP    = 3'd6
	} reg_t;

	typedef enum logic [1:0] {
		K_POINT   = 2'd0,
		K_CLEAR   = 2'd1,
		K_INVALID = 2'd2,
		K_OUTSIDE = 2'd3
	} kind_t;

	typedef struct packed {
		logic [31:0]      inv_x;
		logic [31:0]      inv_y;
		logic [31:0]      inv_z;
		logic [31:0]      org_x;
		logic [31:0]      org_y;
		logic [31:0]      org_z;
		logic [CNT_W-1:0] cap;
	} cfg_t;

	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] idx;
	} qent_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [CNT_W-1:0]   cnt;
	} cword_t;

endpackage

// ----- design/vcpf_cfg.sv -----
// configuration register file behind the apb-style port
module vcpf_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vcpf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output vcpf_pkg::cfg_t             cfg
);

	vcpf_pkg::cfg_t cfg_q;
	vcpf_pkg::reg_t sel;
	logic           wr;

	assign sel    = vcpf_pkg::reg_t'(paddr[vcpf_pkg::ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_x <= 32'd65536;
			cfg_q.inv_y <= 32'd65536;
			cfg_q.inv_z <= 32'd65536;
			cfg_q.org_x <= 32'd0;
			cfg_q.org_y <= 32'd0;
			cfg_q.org_z <= 32'd0;
			cfg_q.cap   <= vcpf_pkg::CNT_W'(1);
		end else if (wr) begin
			unique case (sel)
				vcpf_pkg::REG_INV_X: cfg_q.inv_x <= pwdata;
				vcpf_pkg::REG_INV_Y: cfg_q.inv_y <= pwdata;
				vcpf_pkg::REG_INV_Z: cfg_q.inv_z <= pwdata;
				vcpf_pkg::REG_ORG_X: cfg_q.org_x <= pwdata;
				vcpf_pkg::REG_ORG_Y: cfg_q.org_y <= pwdata;
				vcpf_pkg::REG_ORG_Z: cfg_q.org_z <= pwdata;
				vcpf_pkg::REG_CAP:   cfg_q.cap   <= pwdata[vcpf_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			vcpf_pkg::REG_INV_X: prdata = cfg_q.inv_x;
			vcpf_pkg::REG_INV_Y: prdata = cfg_q.inv_y;
			vcpf_pkg::REG_INV_Z: prdata = cfg_q.inv_z;
			vcpf_pkg::REG_ORG_X: prdata = cfg_q.org_x;
			vcpf_pkg::REG_ORG_Y: prdata = cfg_q.org_y;
			vcpf_pkg::REG_ORG_Z: prdata = cfg_q.org_z;
			vcpf_pkg::REG_CAP:   prdata = 32'(cfg_q.cap);
			default:             prdata = 32'd0;
		endcase
	end

endmodule

// ----- design/vcpf_front.sv -----
// front end: takes requests, scales coordinates and classifies them into queue entries
module vcpf_front #(
	parameter int GRID_X = vcpf_pkg::GRID_X_DEF,
	parameter int GRID_Y = vcpf_pkg::GRID_Y_DEF,
	parameter int GRID_Z = vcpf_pkg::GRID_Z_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vcpf_pkg::cfg_t      cfg,
	input  logic                push,
	output logic                full,
	input  logic                command,
	input  logic signed [31:0]  px,
	input  logic signed [31:0]  py,
	input  logic signed [31:0]  pz,
	input  logic                coords_finite,
	input  logic                busy,
	output logic                q_push,
	output vcpf_pkg::qent_t     q_ent,
	input  logic                q_full
);

	localparam int GXY = GRID_X * GRID_Y;

	logic               v_s1, cmd_s1, fin_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic               v_s2, cmd_s2, fin_s2;
	logic [63:0]        prx_s2, pry_s2, prz_s2;

	logic signed [64:0] mx, my, mz;
	logic               adv, accept;
	logic [32:0]        gx, gy, gz;
	logic               in_grid;
	logic [31:0]        lin;

	assign adv    = !v_s2 || !q_full;
	assign full   = !adv || busy;
	assign accept = push && !full;
	assign q_push = v_s2 && adv;

	// signed coordinate times unsigned inverse leaf size, exact q32.32 product
	assign mx = px_s1 * $signed({1'b0, cfg.inv_x});
	assign my = py_s1 * $signed({1'b0, cfg.inv_y});
	assign mz = pz_s1 * $signed({1'b0, cfg.inv_z});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= command;
			fin_s1 <= coords_finite;
			px_s1  <= px;
			py_s1  <= py;
			pz_s1  <= pz;
			cmd_s2 <= cmd_s1;
			fin_s2 <= fin_s1;
			prx_s2 <= mx[63:0];
			pry_s2 <= my[63:0];
			prz_s2 <= mz[63:0];
		end
	end

	// floor is the upper word of the product; grid coordinate is 33-bit signed
	always_comb begin
		gx = {prx_s2[63], prx_s2[63:32]} - {cfg.org_x[31], cfg.org_x};
		gy = {pry_s2[63], pry_s2[63:32]} - {cfg.org_y[31], cfg.org_y};
		gz = {prz_s2[63], prz_s2[63:32]} - {cfg.org_z[31], cfg.org_z};
		in_grid = !gx[32] && (gx[31:0] < 32'(GRID_X)) &&
		          !gy[32] && (gy[31:0] < 32'(GRID_Y)) &&
		          !gz[32] && (gz[31:0] < 32'(GRID_Z));
		lin = 32'(gx[vcpf_pkg::CRD_W-1:0]) +
		      32'(gy[vcpf_pkg::CRD_W-1:0]) * 32'(GRID_X) +
		      32'(gz[vcpf_pkg::CRD_W-1:0]) * 32'(GXY);
		q_ent.idx = '0;
		if (cmd_s2) begin
			q_ent.kind = vcpf_pkg::K_CLEAR;
		end else if (!fin_s2) begin
			q_ent.kind = vcpf_pkg::K_INVALID;
		end else if (!in_grid) begin
			q_ent.kind = vcpf_pkg::K_OUTSIDE;
		end else begin
			q_ent.kind = vcpf_pkg::K_POINT;
			q_ent.idx  = lin[vcpf_pkg::IDX_W-1:0];
		end
	end

endmodule

// ----- design/vcpf_queue.sv -----
// short fifo of classified entries between front and back
module vcpf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vcpf_pkg::qent_t din,
	output logic            full,
	input  logic            pop,
	output vcpf_pkg::qent_t dout,
	output logic            empty
);

	vcpf_pkg::qent_t           ent_q [vcpf_pkg::Q_DEPTH];
	logic [vcpf_pkg::QA_W-1:0] wptr_q, rptr_q;
	logic [vcpf_pkg::QA_W:0]   cnt_q;
	logic                      do_push, do_pop;

	assign full    = cnt_q == (vcpf_pkg::QA_W+1)'(vcpf_pkg::Q_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop) rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wptr_q] <= din;
	end

endmodule

// ----- design/vcpf_back.sv -----
// back end: voxel count table with epoch tags, read-modify-write and result stage
module vcpf_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vcpf_pkg::cfg_t              cfg,
	input  logic                        q_empty,
	input  vcpf_pkg::qent_t             q_ent,
	output logic                        q_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic                        keep,
	output logic [2:0]                  status,
	output logic [vcpf_pkg::IDX_W-1:0]  voxel_index,
	output logic                        busy
);

	vcpf_pkg::cword_t mem [vcpf_pkg::DEPTH];

	logic                         v_s3;
	vcpf_pkg::qent_t              ent_s3;
	vcpf_pkg::cword_t             rdata_s3;
	logic                         fwd_v_q;
	logic [vcpf_pkg::IDX_W-1:0]   fwd_idx_q;
	vcpf_pkg::cword_t             fwd_data_q;
	logic [vcpf_pkg::EPOCH_W-1:0] epoch_q;
	logic                         sweep_q;
	logic [vcpf_pkg::IDX_W-1:0]   sweep_addr_q;

	logic                         leave, wrap_clear, take;
	vcpf_pkg::cword_t             cur;
	logic [vcpf_pkg::CNT_W-1:0]   cnt;
	logic                         room;
	vcpf_pkg::status_t            st;
	logic                         we;
	logic [vcpf_pkg::IDX_W-1:0]   waddr;
	vcpf_pkg::cword_t             wdata;

	assign leave      = v_s3 && pop;
	// a clear at the last epoch starts a sweep, so nothing may be read behind it
	assign wrap_clear = v_s3 && (ent_s3.kind == vcpf_pkg::K_CLEAR) && (epoch_q == '1);
	assign take       = !q_empty && !sweep_q && !wrap_clear && (!v_s3 || pop);
	assign q_pop      = take;
	assign empty      = !v_s3;
	assign busy       = sweep_q;

	always_comb begin
		cur  = (fwd_v_q && fwd_idx_q == ent_s3.idx) ? fwd_data_q : rdata_s3;
		cnt  = (cur.tag == epoch_q) ? cur.cnt : '0;
		room = cnt < cfg.cap;
		keep = 1'b0;
		unique case (ent_s3.kind)
			vcpf_pkg::K_POINT: begin
				keep = room;
				st   = room ? vcpf_pkg::ST_KEPT : vcpf_pkg::ST_FULL;
			end
			vcpf_pkg::K_CLEAR:   st = vcpf_pkg::ST_CLEARED;
			vcpf_pkg::K_INVALID: st = vcpf_pkg::ST_INVALID;
			vcpf_pkg::K_OUTSIDE: st = vcpf_pkg::ST_OUTSIDE;
			default:             st = vcpf_pkg::ST_INVALID;
		endcase
		status      = st;
		voxel_index = ent_s3.idx;
		if (sweep_q) begin
			we    = 1'b1;
			waddr = sweep_addr_q;
			wdata = '0;
		end else begin
			we        = leave && (ent_s3.kind == vcpf_pkg::K_POINT) && room;
			waddr     = ent_s3.idx;
			wdata.tag = epoch_q;
			wdata.cnt = cnt + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (take) rdata_s3 <= mem[q_ent.idx];
	end

	always_ff @(posedge clk) begin
		if (take) ent_s3 <= q_ent;
		if (we && !sweep_q) begin
			fwd_idx_q  <= waddr;
			fwd_data_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3         <= 1'b0;
			fwd_v_q      <= 1'b0;
			epoch_q      <= vcpf_pkg::EPOCH_W'(1);
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else begin
			if (take) v_s3 <= 1'b1;
			else if (pop) v_s3 <= 1'b0;

			if (sweep_q) begin
				sweep_addr_q <= sweep_addr_q + 1'b1;
				if (sweep_addr_q == '1) sweep_q <= 1'b0;
			end

			if (we && !sweep_q) begin
				fwd_v_q <= 1'b1;
			end else if (leave && ent_s3.kind == vcpf_pkg::K_CLEAR) begin
				fwd_v_q <= 1'b0;
				if (epoch_q == '1) begin
					epoch_q      <= vcpf_pkg::EPOCH_W'(1);
					sweep_q      <= 1'b1;
					sweep_addr_q <= '0;
				end else begin
					epoch_q <= epoch_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- design/voxel_capped_point_filter_top.sv -----
// top level of the voxel capped point filter
// one request accepted per cycle while full is low; its result goes through s1, s2, the queue and s3
// one result per cycle while popped, no sweep, set by one-read one-write table rmw with forwarding
// after reset the count table is swept, all 4096 entries, with full held high
// every 255th clear command starts the same sweep once its result is popped
// reset restores register defaults and empties the pipeline and queue
module voxel_capped_point_filter_top #(
	parameter int GRID_X = vcpf_pkg::GRID_X_DEF,
	parameter int GRID_Y = vcpf_pkg::GRID_Y_DEF,
	parameter int GRID_Z = vcpf_pkg::GRID_Z_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vcpf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic                        command,
	input  logic signed [31:0]          px,
	input  logic signed [31:0]          py,
	input  logic signed [31:0]          pz,
	input  logic                        coords_finite,
	output logic                        empty,
	input  logic                        pop,
	output logic                        keep,
	output logic [2:0]                  status,
	output logic [vcpf_pkg::IDX_W-1:0]  voxel_index
);

	vcpf_pkg::cfg_t  cfg;
	logic            busy;
	logic            q_push, q_full, q_pop, q_empty;
	vcpf_pkg::qent_t q_din, q_dout;

	vcpf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vcpf_front #(
		.GRID_X (GRID_X),
		.GRID_Y (GRID_Y),
		.GRID_Z (GRID_Z)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.push          (push),
		.full          (full),
		.command       (command),
		.px            (px),
		.py            (py),
		.pz            (pz),
		.coords_finite (coords_finite),
		.busy          (busy),
		.q_push        (q_push),
		.q_ent         (q_din),
		.q_full        (q_full)
	);

	vcpf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	vcpf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_empty     (q_empty),
		.q_ent       (q_dout),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.keep        (keep),
		.status      (status),
		.voxel_index (voxel_index),
		.busy        (busy)
	);

	// no request is taken while the count table is being swept
	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> full)
		else $error("request accepted during table sweep");

	// keep flag and kept status agree on every waiting result
	a_keep_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (keep == (status == vcpf_pkg::ST_KEPT)))
		else $error("keep and status disagree");

	// only kept or full points carry a voxel index
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == vcpf_pkg::ST_CLEARED || status == vcpf_pkg::ST_INVALID ||
		            status == vcpf_pkg::ST_OUTSIDE)) |-> (voxel_index == '0))
		else $error("voxel index set on a result without a voxel");

	// the front never hands an entry to a full queue
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue overflow");

endmodule

// ----- tb/tb_voxel_capped_point_filter_top.sv -----
// self-checking testbench for the voxel capped point filter: directed and random points, clears and register settings
module tb_voxel_capped_point_filter_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        command;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        finite;
	} point_req_t;

	typedef struct {
		logic                       keep;
		vcpf_pkg::status_t          status;
		logic [vcpf_pkg::IDX_W-1:0] idx;
	} verdict_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [vcpf_pkg::ADDR_W-1:0]   paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          push = 1'b0;
	logic                          full;
	logic                          command = 1'b0;
	logic signed [31:0]            px = '0;
	logic signed [31:0]            py = '0;
	logic signed [31:0]            pz = '0;
	logic                          coords_finite = 1'b0;
	logic                          empty;
	logic                          pop = 1'b0;
	logic                          keep;
	logic [2:0]                    status;
	logic [vcpf_pkg::IDX_W-1:0]    voxel_index;

	// predictor copy of the registers and the count table
	logic [31:0]         inv_cfg [3];
	logic signed [31:0]  org_cfg [3];
	logic [7:0]          cap_cfg;
	bit                  used_map [vcpf_pkg::DEPTH];
	logic [7:0]          count_map [vcpf_pkg::DEPTH];
	int                  grid_dim [3] = '{vcpf_pkg::GRID_X_DEF, vcpf_pkg::GRID_Y_DEF,
		vcpf_pkg::GRID_Z_DEF};

	point_req_t          points_to_send [$];
	verdict_t            pending_verdicts [$];
	point_req_t          cur_point;
	verdict_t            want;
	logic                req_taken = 1'b0;
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	int                  mismatches = 0;
	int                  clears_queued = 0;
	bit                  hold_req = 1'b0;
	bit                  holding = 1'b0;

	voxel_capped_point_filter_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.push          (push),
		.full          (full),
		.command       (command),
		.px            (px),
		.py            (py),
		.pz            (pz),
		.coords_finite (coords_finite),
		.empty         (empty),
		.pop           (pop),
		.keep          (keep),
		.status        (status),
		.voxel_index   (voxel_index)
	);

	always #6 clk = ~clk;

	function automatic verdict_t judge_point(point_req_t r);
		verdict_t    v;
		logic [31:0] crd [3];
		longint      g [3];
		longint      prod;
		longint      lin;
		logic [7:0]  cnt;
		v.keep = 1'b0;
		v.status = vcpf_pkg::ST_KEPT;
		v.idx = '0;
		if (r.command) begin
			foreach (used_map[i]) used_map[i] = 1'b0;
			v.status = vcpf_pkg::ST_CLEARED;
			return v;
		end
		if (!r.finite) begin
			v.status = vcpf_pkg::ST_INVALID;
			return v;
		end
		crd[0] = r.x;
		crd[1] = r.y;
		crd[2] = r.z;
		for (int a = 0; a < 3; a++) begin
			// exact q32.32 product, arithmetic shift floors toward minus infinity
			prod = longint'($signed(crd[a])) * longint'({32'b0, inv_cfg[a]});
			g[a] = (prod >>> 32) - longint'(org_cfg[a]);
			if (g[a] < 0 || g[a] >= grid_dim[a]) begin
				v.status = vcpf_pkg::ST_OUTSIDE;
				return v;
			end
		end
		lin = g[0] + grid_dim[0] * g[1] + grid_dim[0] * grid_dim[1] * g[2];
		v.idx = lin[vcpf_pkg::IDX_W-1:0];
		cnt = used_map[v.idx] ? count_map[v.idx] : 8'd0;
		if (cnt < cap_cfg) begin
			count_map[v.idx] = cnt + 8'd1;
			used_map[v.idx] = 1'b1;
			v.keep = 1'b1;
			v.status = vcpf_pkg::ST_KEPT;
		end else begin
			v.status = vcpf_pkg::ST_FULL;
		end
		return v;
	endfunction

	// raw coordinate that lands in or next to voxel coordinate v
	function automatic logic [31:0] raw_in_voxel(longint v, logic [31:0] inv);
		longint width;
		longint p;
		if (v > 64'sd2147483000 || v < -64'sd2147483000)
			return $urandom();
		width = 64'sd4294967296 / longint'({32'b0, inv});
		p = (v <<< 32) / longint'({32'b0, inv});
		p += longint'($urandom_range(32'(width - 1)));
		if (p > 64'sh7fff_ffff || p < -64'sh8000_0000)
			return $urandom();
		return p[31:0];
	endfunction

	function automatic point_req_t random_point(int clr_pct);
		point_req_t  r;
		int          roll;
		longint      g;
		logic [31:0] crd [3];
		r.command = ($urandom_range(99) < clr_pct);
		r.finite = 1'b1;
		crd[0] = $urandom();
		crd[1] = $urandom();
		crd[2] = $urandom();
		roll = $urandom_range(99);
		if (r.command) begin
			r.finite = $urandom_range(1);
		end else if (roll < 5) begin
			r.finite = 1'b0;
		end else if (roll >= 15) begin
			// aim at a voxel, mostly a few hot ones so the cap is reached
			for (int a = 0; a < 3; a++) begin
				if ($urandom_range(19) == 0)
					g = $urandom_range(1) ? -1 : grid_dim[a];
				else if ($urandom_range(1))
					g = $urandom_range(3);
				else
					g = $urandom_range(grid_dim[a] - 1);
				crd[a] = raw_in_voxel(longint'(org_cfg[a]) + g, inv_cfg[a]);
			end
		end
		r.x = crd[0];
		r.y = crd[1];
		r.z = crd[2];
		return r;
	endfunction

	function automatic void queue_point(logic cmd, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic fin);
		point_req_t r;
		r.command = cmd;
		r.x = x;
		r.y = y;
		r.z = z;
		r.finite = fin;
		points_to_send.insert(points_to_send.size(), r);
		if (cmd)
			clears_queued++;
	endfunction

	task automatic write_reg(vcpf_pkg::reg_t which, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_settings(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
			logic [31:0] ox, logic [31:0] oy, logic [31:0] oz, logic [7:0] cap);
		write_reg(vcpf_pkg::REG_INV_X, ix);
		write_reg(vcpf_pkg::REG_INV_Y, iy);
		write_reg(vcpf_pkg::REG_INV_Z, iz);
		write_reg(vcpf_pkg::REG_ORG_X, ox);
		write_reg(vcpf_pkg::REG_ORG_Y, oy);
		write_reg(vcpf_pkg::REG_ORG_Z, oz);
		write_reg(vcpf_pkg::REG_CAP, {24'b0, cap});
		inv_cfg = '{ix, iy, iz};
		org_cfg = '{ox, oy, oz};
		cap_cfg = cap;
	endtask

	task automatic apply_random_settings(bit wide, logic [7:0] cap);
		logic [31:0] inv [3];
		logic [31:0] org [3];
		foreach (inv[a]) begin
			inv[a] = wide ? $urandom_range(32'hFFFF_FFFF, 1)
				: $urandom_range(32'h0008_0000, 32'h0000_4000);
			org[a] = 32'($urandom_range(80)) - 32'd40;
		end
		apply_settings(inv[0], inv[1], inv[2], org[0], org[1], org[2], cap);
	endtask

	task automatic await_drain();
		do @(posedge clk);
		while (points_to_send.size() != 0 || push || pending_verdicts.size() != 0);
	endtask

	task automatic run_batch(int n, int clr_pct, int send_pct, int recv_pct, int clear_goal);
		point_req_t r;
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < n || clears_queued < clear_goal; i++) begin
			r = random_point(clr_pct);
			queue_point(r.command, r.x, r.y, r.z, r.finite);
		end
		await_drain();
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!push || req_taken)) begin
			if (points_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_point = points_to_send.pop_front();
				push <= 1'b1;
				command <= cur_point.command;
				px <= cur_point.x;
				py <= cur_point.y;
				pz <= cur_point.z;
				coords_finite <= cur_point.finite;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		pop <= arst_n && !holding && ($urandom_range(99) >= recv_stall_pct);

	// checks results first, then records the request taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: keep %0d status %0d index %0d",
							keep, status, voxel_index);
				end else begin
					want = pending_verdicts.pop_front();
					if (keep !== want.keep || status !== want.status ||
							voxel_index !== want.idx) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected keep %0d status %0d index %0d, %s %0d %0d %0d",
								$realtime, want.keep, want.status, want.idx,
								"got", keep, status, voxel_index);
					end
				end
			end
			if (push && !full)
				pending_verdicts.insert(pending_verdicts.size(), judge_point(cur_point));
			req_taken <= push && !full;
		end
	end

	// long receiver hold-off so the block fills and backs up the sender
	initial begin
		wait (hold_req);
		@(posedge clk);
		holding = 1'b1;
		repeat (300) @(posedge clk);
		holding = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		inv_cfg = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
		org_cfg = '{32'sd0, 32'sd0, 32'sd0};
		cap_cfg = 8'd1;
		foreach (used_map[i]) begin
			used_map[i] = 1'b0;
			count_map[i] = 8'd0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// register defaults: unit leaf, origin zero, cap one
		@(posedge clk);
		queue_point(1'b0, 32'h0, 32'h0, 32'h0, 1'b1);
		queue_point(1'b0, 32'h0, 32'h0, 32'h0, 1'b1);
		queue_point(1'b0, 32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, 1'b1);
		queue_point(1'b0, 32'h0010_0000, 32'h0, 32'h0, 1'b1);
		queue_point(1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
		queue_point(1'b0, 32'h0, 32'h0010_0000, 32'h0, 1'b1);
		queue_point(1'b0, 32'h0, 32'h0, 32'h0010_0000, 1'b1);
		queue_point(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
		queue_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		queue_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
		queue_point(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		queue_point(1'b0, 32'h0, 32'h0, 32'h0, 1'b1);
		queue_point(1'b0, 32'h0005_8000, 32'h0003_4000, 32'h0007_C000, 1'b1);
		queue_point(1'b1, 32'h0, 32'h0, 32'h0, 1'b0);
		await_drain();

		// largest inverse leaf with the lowest origin, most negative point lands in voxel 0
		apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd255);
		@(posedge clk);
		queue_point(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		queue_point(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		queue_point(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		await_drain();

		// smallest inverse leaf and zero cap: everything in grid is full
		apply_settings(32'h1, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
		@(posedge clk);
		queue_point(1'b0, 32'h0, 32'h0, 32'h0, 1'b1);
		queue_point(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		queue_point(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		await_drain();

		apply_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 8'd2);
		run_batch(30, 8, 0, 0, 0);

		apply_random_settings(1'b0, 8'($urandom_range(4, 1)));
		run_batch(30, 8, 80, 0, 0);

		apply_random_settings(1'b0, 8'($urandom_range(4, 1)));
		run_batch(30, 8, 0, 80, 0);

		apply_random_settings(1'b0, 8'($urandom_range(255, 1)));
		run_batch(30, 8, 37, 37, 0);

		apply_random_settings(1'b0, 8'd2);
		hold_req = 1'b1;
		run_batch(40, 8, 0, 0, 0);

		// enough clears to wrap the count table tags and force a sweep
		apply_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 8'd1);
		run_batch(0, 95, 37, 37, 262);

		apply_random_settings(1'b1, 8'd0);
		run_batch(30, 8, 80, 0, 0);

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
